// ===== design/sclr_pkg.sv =====
`timescale 1ns / 1ps

package sclr_pkg;

	// table geometry
	localparam int TABLE_DEPTH  = 32;
	localparam int WARMUP_STEPS = 8;
	localparam int INIT_STEPS   = TABLE_DEPTH + WARMUP_STEPS;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W        = $clog2(INIT_STEPS + 1);

	// word widths
	localparam int SEED_W  = 32;
	localparam int GEN_W   = 31;
	localparam int RANGE_W = 16;
	localparam int SPAN_W  = RANGE_W + 1;
	localparam int MUL_W   = 16;
	localparam int FOLD_W  = 8;
	localparam int PROD_W  = GEN_W + MUL_W;
	localparam int SC_W    = GEN_W + SPAN_W;

	// request word modes
	localparam logic MODE_DRAW = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// generator constants, moduli are 2^31 minus the fold value
	localparam logic [GEN_W-1:0]  MOD1  = 31'd2147483563;
	localparam logic [GEN_W-1:0]  MOD2  = 31'd2147483399;
	localparam logic [MUL_W-1:0]  MUL1  = 16'd40014;
	localparam logic [MUL_W-1:0]  MUL2  = 16'd40692;
	localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;
	localparam logic [GEN_W-1:0]  MODM1 = 31'd2147483562;

	// top clamp of the raw word before scaling (1 - 1.2e-7 of the modulus)
	localparam logic [GEN_W-1:0] RAW_CLAMP = 31'd2147483305;

	// slot selection: slot = raw / SLOT_DIV via reciprocal estimate and one correction
	localparam longint SLOT_DIV_L = 64'd1 + (64'd2147483562 / TABLE_DEPTH);
	localparam longint RECIP_L    = (64'd1 << GEN_W) / SLOT_DIV_L;
	localparam int     QW         = ADDR_W + 1;
	localparam logic [GEN_W-1:0] SLOT_DIV = GEN_W'(SLOT_DIV_L);
	localparam logic [QW-1:0]    RECIP    = QW'(RECIP_L);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_MUL,
		ST_W_RED,
		ST_SETTLE,
		ST_D_MUL,
		ST_D_RED,
		ST_D_MIX,
		ST_D_SCALE,
		ST_D_OUT
	} state_t;

	typedef struct packed {
		logic load_seed;
		logic capture;
		logic fix;
		logic warm_mul;
		logic warm_red;
		logic draw_mul;
		logic draw_red;
		logic mix;
		logic scale;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_init;
		logic cnt_zero;
	} status_t;

endpackage

// ===== design/sclr_if.sv =====
`timescale 1ns / 1ps

// request channel: draw or seed load
interface sclr_in_if;
	import sclr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [SEED_W-1:0]  seed_value;
	logic [RANGE_W-1:0]        range_low;
	logic [RANGE_W-1:0]        range_high;

	modport source (output valid, mode, seed_value, range_low, range_high, input ready);
	modport sink   (input valid, mode, seed_value, range_low, range_high, output ready);
endinterface

// result channel: one word per draw
interface sclr_out_if;
	import sclr_pkg::*;

	logic               valid;
	logic               ready;
	logic [GEN_W-1:0]   raw_value;
	logic [RANGE_W-1:0] scaled_value;
	logic               range_error;

	modport source (output valid, raw_value, scaled_value, range_error, input ready);
	modport sink   (input valid, raw_value, scaled_value, range_error, output ready);
endinterface

// ===== design/sclr_ram.sv =====
`timescale 1ns / 1ps

module sclr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/sclr_ctrl.sv =====
`timescale 1ns / 1ps

module sclr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	input  logic              out_ready,
	input  sclr_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output sclr_pkg::cmd_t    cmd
);
	import sclr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	// request words are taken only while idle
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_mode == MODE_DRAW) begin
					state_d = status.need_init ? ST_W_MUL : ST_D_RED;
				end
			end
			ST_W_MUL:   state_d = ST_W_RED;
			ST_W_RED:   state_d = status.cnt_zero ? ST_SETTLE : ST_W_MUL;
			ST_SETTLE:  state_d = ST_D_MUL;
			ST_D_MUL:   state_d = ST_D_RED;
			ST_D_RED:   state_d = ST_D_MIX;
			ST_D_MIX:   state_d = ST_D_SCALE;
			ST_D_SCALE: state_d = ST_D_OUT;
			ST_D_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load_seed = (in_mode == MODE_LOAD);
					cmd.capture   = (in_mode == MODE_DRAW);
					cmd.fix       = (in_mode == MODE_DRAW) && status.need_init;
					cmd.draw_mul  = (in_mode == MODE_DRAW) && !status.need_init;
				end
			end
			ST_W_MUL:   cmd.warm_mul = 1'b1;
			ST_W_RED:   cmd.warm_red = 1'b1;
			ST_SETTLE:  cmd          = '0;
			ST_D_MUL:   cmd.draw_mul = 1'b1;
			ST_D_RED:   cmd.draw_red = 1'b1;
			ST_D_MIX:   cmd.mix      = 1'b1;
			ST_D_SCALE: cmd.scale    = 1'b1;
			ST_D_OUT:   cmd.out_load = out_free;
			default:    cmd          = '0;
		endcase
	end

	// state and result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== design/sclr_dp.sv =====
`timescale 1ns / 1ps

module sclr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sclr_pkg::cmd_t                       cmd,
	output sclr_pkg::status_t                    status,
	input  logic signed [sclr_pkg::SEED_W-1:0]   seed_value,
	input  logic [sclr_pkg::RANGE_W-1:0]         range_low,
	input  logic [sclr_pkg::RANGE_W-1:0]         range_high,
	output logic [sclr_pkg::GEN_W-1:0]           raw_value,
	output logic [sclr_pkg::RANGE_W-1:0]         scaled_value,
	output logic                                 range_error
);
	import sclr_pkg::*;

	// a*z mod (2^31 - fold): fold the high part down, one conditional subtract
	function automatic logic [GEN_W-1:0] gen_reduce(
		input logic [PROD_W-1:0] p,
		input logic [GEN_W-1:0]  m,
		input logic [FOLD_W-1:0] fold
	);
		logic [MUL_W+FOLD_W-1:0] f;
		logic [GEN_W:0]          s;
		begin
			f = p[PROD_W-1:GEN_W] * fold;
			s = {1'b0, p[GEN_W-1:0]} + (GEN_W+1)'(f);
			if (s >= {1'b0, m}) begin
				s = s - {1'b0, m};
			end
			return s[GEN_W-1:0];
		end
	endfunction

	logic signed [SEED_W-1:0] g1_q;
	logic [GEN_W-1:0]         g2_q;
	logic [GEN_W-1:0]         sout_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [RANGE_W-1:0]       lo_q;
	logic [RANGE_W-1:0]       hi_q;
	logic [PROD_W-1:0]        prod1_q;
	logic [PROD_W-1:0]        prod2_q;
	logic [SC_W-1:0]          prod_sc_q;
	logic [GEN_W-1:0]         raw_q;
	logic [RANGE_W-1:0]       scaled_q;
	logic                     err_q;

	logic [GEN_W-1:0]         red1;
	logic [GEN_W-1:0]         red2;
	logic [SEED_W-1:0]        g1_neg;
	logic [GEN_W-1:0]         g1_fixed;

	logic [GEN_W-1:0]         sout_s1;
	logic [QW-1:0]            qest_s1;
	logic [ADDR_W-1:0]        slot_s2;
	logic [GEN_W+QW-1:0]      est_prod;
	logic [GEN_W+QW-1:0]      back_prod;
	logic [GEN_W:0]           slot_rem;
	logic [QW-1:0]            slot_full;
	logic [ADDR_W-1:0]        slot_next;

	logic [GEN_W-1:0]         rd_data;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [GEN_W-1:0]         ram_wdata;
	logic [GEN_W:0]           mix_diff;
	logic [GEN_W:0]           mix_wrap;
	logic [GEN_W-1:0]         mix_val;

	logic [GEN_W-1:0]         clamp_raw;
	logic [SPAN_W-1:0]        span;
	logic [SPAN_W+FOLD_W-1:0] sc_fold;
	logic [GEN_W:0]           sc_rem;
	logic [SPAN_W-1:0]        sc_quot;
	logic                     inverted;

	// generator reduction
	assign red1 = gen_reduce(prod1_q, MOD1, FOLD1);
	assign red2 = gen_reduce(prod2_q, MOD2, FOLD2);

	// reseed fix-up: drop the sign, saturate the most negative value, zero becomes one
	assign g1_neg = -g1_q;
	always_comb begin
		if (g1_q[SEED_W-1]) begin
			g1_fixed = g1_neg[SEED_W-1] ? {GEN_W{1'b1}} : g1_neg[GEN_W-1:0];
		end else if (g1_q == '0) begin
			g1_fixed = GEN_W'(1);
		end else begin
			g1_fixed = g1_q[GEN_W-1:0];
		end
	end

	assign status.need_init = g1_q[SEED_W-1] || (g1_q == '0) || (sout_q == '0);
	assign status.cnt_zero  = (cnt_q == '0);

	// generator and shuffle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q   <= '0;
			g2_q   <= '0;
			sout_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.load_seed) begin
				g1_q <= seed_value;
			end else if (cmd.fix) begin
				g1_q <= {1'b0, g1_fixed};
			end else if (cmd.warm_red || cmd.draw_red) begin
				g1_q <= {1'b0, red1};
			end

			if (cmd.fix) begin
				g2_q <= g1_fixed;
			end else if (cmd.draw_red) begin
				g2_q <= red2;
			end

			if (cmd.fix) begin
				cnt_q <= CNT_W'(INIT_STEPS - 1);
			end else if (cmd.warm_red && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (cmd.warm_red && cnt_q == '0) begin
				sout_q <= red1;
			end else if (cmd.mix) begin
				sout_q <= mix_val;
			end
		end
	end

	// step multipliers and range capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lo_q <= range_low;
			hi_q <= range_high;
		end
		if (cmd.warm_mul || cmd.draw_mul) begin
			prod1_q <= g1_q[GEN_W-1:0] * MUL1;
		end
		if (cmd.draw_mul) begin
			prod2_q <= g2_q * MUL2;
		end
	end

	// slot pipe follows the shuffle output: estimate, then one correction and clamp
	assign est_prod  = sout_q * RECIP;
	assign back_prod = qest_s1 * SLOT_DIV;
	assign slot_rem  = {1'b0, sout_s1} - back_prod[GEN_W:0];
	assign slot_full = qest_s1 + QW'(slot_rem >= {1'b0, SLOT_DIV});
	assign slot_next = (slot_full > QW'(TABLE_DEPTH - 1)) ? ADDR_W'(TABLE_DEPTH - 1)
		: slot_full[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		sout_s1 <= sout_q;
		qest_s1 <= est_prod[GEN_W+QW-1:GEN_W];
		slot_s2 <= slot_next;
	end

	// shuffle table
	assign ram_we    = (cmd.warm_red && (cnt_q < CNT_W'(TABLE_DEPTH))) || cmd.mix;
	assign ram_waddr = cmd.mix ? slot_s2 : cnt_q[ADDR_W-1:0];
	assign ram_wdata = cmd.mix ? g1_q[GEN_W-1:0] : red1;

	sclr_ram #(
		.WIDTH (GEN_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_s2),
		.rdata (rd_data)
	);

	// table entry minus second generator, wrapped into 1 .. MOD1-1
	assign mix_diff = {1'b0, rd_data} - {1'b0, g2_q};
	assign mix_wrap = mix_diff + {1'b0, MODM1};
	assign mix_val  = (mix_diff[GEN_W] || mix_diff == '0) ? mix_wrap[GEN_W-1:0]
		: mix_diff[GEN_W-1:0];

	// scaling: clamp, multiply by span, divide by MOD1 with one fold and compare
	assign clamp_raw = (sout_q > RAW_CLAMP) ? RAW_CLAMP : sout_q;
	assign span      = {1'b0, hi_q} - {1'b0, lo_q} + SPAN_W'(1);
	assign inverted  = hi_q < lo_q;
	assign sc_fold   = prod_sc_q[SC_W-1:GEN_W] * FOLD1;
	assign sc_rem    = {1'b0, prod_sc_q[GEN_W-1:0]} + (GEN_W+1)'(sc_fold);
	assign sc_quot   = prod_sc_q[SC_W-1:GEN_W] + SPAN_W'(sc_rem >= {1'b0, MOD1});

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			prod_sc_q <= clamp_raw * span;
		end
		if (cmd.out_load) begin
			raw_q    <= sout_q;
			err_q    <= inverted;
			scaled_q <= inverted ? lo_q : lo_q + sc_quot[RANGE_W-1:0];
		end
	end

	assign raw_value    = raw_q;
	assign scaled_value = scaled_q;
	assign range_error  = err_q;
endmodule

// ===== design/shuffled_combined_lcg_random.sv =====
`timescale 1ns / 1ps

// Shuffled combined congruential random source. Each request word either loads the
// seed (mode 1, stored on acceptance, no result) or draws a number (mode 0), which
// returns one result word: the shuffled raw value and that value scaled into
// [range_low, range_high], with range_error set and the low bound returned when the
// range is inverted. Once a draw is accepted, the result register is loaded when it
// is free, after a generator step (multiply, then modular fold, alongside a
// registered read of the shuffle table), the mix, and the scaling multiply. The next
// request word can be taken the cycle after, so a new draw is accepted only once the
// previous one has loaded its result. A draw made right after reset, or while the
// seed is zero or negative, first reseeds: (TABLE_DEPTH + WARMUP_STEPS) steps of the
// first generator, each a multiply then a fold, fill the table before the draw.
// A finished result waits in its output register while the next request is taken.
module shuffled_combined_lcg_random (
	input logic       clk,
	input logic       arst_n,
	sclr_in_if.sink   req,
	sclr_out_if.source rsp
);
	import sclr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	sclr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_mode   (req.mode),
		.out_ready (rsp.ready),
		.status    (status),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	// generators, shuffle table and scaling
	sclr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.seed_value   (req.seed_value),
		.range_low    (req.range_low),
		.range_high   (req.range_high),
		.raw_value    (rsp.raw_value),
		.scaled_value (rsp.scaled_value),
		.range_error  (rsp.range_error)
	);
endmodule

// ===== tb/shuffled_combined_lcg_random_tb.sv =====
`timescale 1ns / 1ps

module shuffled_combined_lcg_random_tb;
	import sclr_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int IDLE_PCT     = 35;
	localparam int RANDOM_WORDS = 1600;
	localparam int HOLD_CYCLES  = 250;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;

	// predicts the shuffled generator and holds the draws still owed
	class rng_scoreboard;
		typedef struct {
			logic [GEN_W-1:0]   raw;
			logic [RANGE_W-1:0] scaled;
			logic               err;
		} draw_t;

		longint gen_a;
		longint gen_b;
		longint shuffled;
		longint slots [TABLE_DEPTH];
		draw_t  owed_q [$];
		int     errors;

		function new();
			gen_a    = 0;
			gen_b    = 0;
			shuffled = 0;
			errors   = 0;
			foreach (slots[i]) slots[i] = 0;
		endfunction

		// multiplicative congruential step, z is nonnegative
		function longint mcg_step(longint z, longint mul, longint modulus);
			return (z * mul) % modulus;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_request(bit mode, logic signed [SEED_W-1:0] seed,
				logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
			longint slot;
			longint c;
			longint span;
			draw_t  d;

			if (mode == MODE_LOAD) begin
				gen_a = longint'(seed);
				return;
			end

			// reseed when the first generator is unusable or nothing drawn yet
			if (gen_a <= 0 || shuffled == 0) begin
				if (gen_a < 0) begin
					gen_a = -gen_a;
					if (gen_a > 64'd2147483647) gen_a = 64'd2147483647;
				end else if (gen_a == 0) begin
					gen_a = 1;
				end
				gen_b = gen_a;
				for (int i = INIT_STEPS - 1; i >= 0; i--) begin
					gen_a = mcg_step(gen_a, longint'(MUL1), longint'(MOD1));
					if (i < TABLE_DEPTH) slots[i] = gen_a;
				end
				shuffled = slots[0];
			end

			gen_a = mcg_step(gen_a, longint'(MUL1), longint'(MOD1));
			gen_b = mcg_step(gen_b, longint'(MUL2), longint'(MOD2));

			// shuffle table lookup and refill
			slot = shuffled / longint'(SLOT_DIV);
			if (slot < 0) slot = 0;
			if (slot > TABLE_DEPTH - 1) slot = TABLE_DEPTH - 1;
			shuffled = slots[slot] - gen_b;
			slots[slot] = gen_a;
			if (shuffled < 1) shuffled += longint'(MODM1);

			d.raw = shuffled[GEN_W-1:0];
			if (hi < lo) begin
				d.err    = 1'b1;
				d.scaled = lo;
			end else begin
				d.err    = 1'b0;
				c        = (shuffled > longint'(RAW_CLAMP)) ? longint'(RAW_CLAMP) : shuffled;
				span     = longint'(hi) - longint'(lo) + 1;
				d.scaled = RANGE_W'(longint'(lo) + (c * span) / longint'(MOD1));
			end
			owed_q.push_back(d);
		endfunction

		function void check_result(logic [GEN_W-1:0] raw, logic [RANGE_W-1:0] scaled,
				logic err);
			draw_t d;

			if (owed_q.size() == 0) begin
				$display("%0t unexpected result word: raw %0d scaled %0d range_error %0b",
					$realtime, raw, scaled, err);
				errors++;
				return;
			end
			d = owed_q.pop_front();
			if (raw !== d.raw) begin
				$display("%0t raw_value: expected %0d actual %0d", $realtime, d.raw, raw);
				errors++;
			end
			if (scaled !== d.scaled) begin
				$display("%0t scaled_value: expected %0d actual %0d", $realtime, d.scaled,
					scaled);
				errors++;
			end
			if (err !== d.err) begin
				$display("%0t range_error: expected %0b actual %0b", $realtime, d.err, err);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sclr_in_if  req ();
	sclr_out_if rsp ();

	shuffled_combined_lcg_random dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rng_scoreboard board;
	bit            idling_on;
	bit            hold_request;
	int            idle_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// known values on every input from time zero
	initial begin
		board          = new();
		idling_on      = 1'b1;
		hold_request   = 1'b0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.mode       = MODE_DRAW;
		req.seed_value = '0;
		req.range_low  = '0;
		req.range_high = '0;
		rsp.ready      = 1'b0;
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready    = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp.ready = !idling_on || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.raw_value, rsp.scaled_value, rsp.range_error);
	end

	// watchdog on cycles with no word moving on either channel
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// offer one request word, called at a falling edge, returns at a falling edge
	task automatic send_word(bit mode, logic [SEED_W-1:0] seed, logic [RANGE_W-1:0] lo,
			logic [RANGE_W-1:0] hi);
		if (idling_on) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req.valid = 1'b0;
				@(negedge clk);
			end
		end
		req.valid      = 1'b1;
		req.mode       = mode;
		req.seed_value = seed;
		req.range_low  = lo;
		req.range_high = hi;
		do @(posedge clk); while (!req.ready);
		board.note_request(mode, seed, lo, hi);
		@(negedge clk);
	endtask

	task automatic draw(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
		send_word(MODE_DRAW, $urandom(), lo, hi);
	endtask

	task automatic load(logic [SEED_W-1:0] seed);
		send_word(MODE_LOAD, seed, RANGE_W'($urandom()), RANGE_W'($urandom()));
	endtask

	// one random word: mostly draws over assorted ranges, a few seed loads
	task automatic random_word();
		logic [SEED_W-1:0]  seed;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		int                 pick;

		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			case ($urandom_range(0, 9))
				0:       seed = 32'd0;
				1:       seed = 32'hFFFF_FFFF;
				2:       seed = 32'h8000_0000;
				3:       seed = 32'h7FFF_FFFF;
				4:       seed = 32'(MOD1);
				5:       seed = 32'(MOD2) + 32'($urandom_range(0, 200));
				6:       seed = 32'($urandom_range(1, 1000));
				default: seed = $urandom();
			endcase
			load(seed);
		end else begin
			lo = RANGE_W'($urandom());
			hi = RANGE_W'($urandom());
			case ($urandom_range(0, 7))
				0: hi = (lo > 16'hFFF0) ? 16'hFFFF : lo + 16'($urandom_range(0, 15));
				1: hi = lo;
				2: begin
					lo = 16'h0000;
					hi = 16'hFFFF;
				end
				3: if (hi >= lo && lo != 16'h0000) hi = lo - 16'd1;
				4: lo = 16'h0000;
				default: ;
			endcase
			draw(lo, hi);
		end
	endtask

	// stimulus and end of run
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first draw after reset reseeds from zero
		draw(16'd0, 16'hFFFF);
		draw(16'd0, 16'd0);
		draw(16'hFFFF, 16'hFFFF);
		draw(16'd1234, 16'd1234);
		draw(16'hFFFF, 16'd0);
		draw(16'd1, 16'd0);
		draw(16'd0, 16'd1);
		// most negative seed saturates on reseed
		load(32'h8000_0000);
		draw(16'd0, 16'hFFFF);
		// largest positive seed, used without reseeding
		load(32'h7FFF_FFFF);
		draw(16'd100, 16'd200);
		// seed equal to the first modulus drives the generator to zero
		load(32'(MOD1));
		draw(16'd0, 16'hFFFF);
		draw(16'd0, 16'hFFFF);
		// seed at the second modulus and above the first
		load(32'(MOD2));
		draw(16'h8000, 16'hFFFF);
		load(32'(MOD1) + 32'd1);
		draw(16'd0, 16'h7FFF);
		// zero and minus one reseed
		load(32'd0);
		draw(16'd0, 16'hFFFF);
		load(32'hFFFF_FFFF);
		draw(16'hFFFF, 16'hFFFE);
		// back-to-back loads, only the last one counts
		load(32'd12345);
		load(32'd777);
		draw(16'd0, 16'hFFFF);

		// random part with a stretch free of random idles and one receiver hold-off
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 400) hold_request = 1'b1;
			if (n == 700) idling_on = 1'b0;
			if (n == 1000) idling_on = 1'b1;
			random_word();
		end
		req.valid = 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sclr_pkg.sv
design/sclr_if.sv
design/sclr_ram.sv
design/sclr_ctrl.sv
design/sclr_dp.sv
design/shuffled_combined_lcg_random.sv
tb/shuffled_combined_lcg_random_tb.sv
